>>> hdl/aes_pkg.sv
// Package: AES constants, S-box functions and round primitives.
package aes_pkg;

  localparam int unsigned KeyW   = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [63:0] IvHighRst = 64'h0001020304050607;
  localparam logic [63:0] IvLowRst  = 64'h08090a0b0c0d0e0f;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_IV_HIGH  = 2'd2,
    CFG_IV_LOW   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  // Control from sequencer to round unit.
  typedef struct packed {
    logic load;     // take in the block and apply first round key
    logic step;     // run one round
    logic decrypt;
    logic last;     // final round: no mix columns
  } rnd_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block, byte 0 most significant.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)&3)+r));
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*((c+r)&3)+r) -: 8] = inv_sbox(get_byte(s, 4*c+r));
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  // Inverse mix: premultiply by {04,00,05,00} then forward mix.
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] p;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      p[127-8*(4*c)   -: 8] = a0 ^ u;
      p[127-8*(4*c+1) -: 8] = a1 ^ v;
      p[127-8*(4*c+2) -: 8] = a2 ^ u;
      p[127-8*(4*c+3) -: 8] = a3 ^ v;
    end
    return mix(p);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> hdl/aes_ram.sv
// Generic RAM with one write port and one registered read port.
module aes_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/aes_round.sv
// Shared round unit: one AES round per cycle while step is set, on the state register.
module aes_round (
  input  logic                 clk,
  input  aes_pkg::rnd_ctl_t    ctl,
  input  logic [127:0]         blk,
  input  logic [127:0]         rkey,
  output logic [127:0]         state
);

  logic [127:0] state_r, state_nxt;
  logic [127:0] enc_t, dec_t;

  // Compute one round either direction
  always_comb begin
    enc_t = aes_pkg::sub_shift(state_r);
    if (!ctl.last) begin
      enc_t = aes_pkg::mix(enc_t);
    end
    enc_t = enc_t ^ rkey;
    dec_t = aes_pkg::inv_sub_shift(state_r) ^ rkey;
    if (!ctl.last) begin
      dec_t = aes_pkg::inv_mix(dec_t);
    end
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = blk ^ rkey;
    end else if (ctl.step) begin
      state_nxt = ctl.decrypt ? dec_t : enc_t;
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule

>>> hdl/aes128_cbc_cipher.sv
// Top level: AES-128 CBC block cipher with key schedule sequencer.
// AES-128 CBC cipher. Each item passes from acceptance to the result register in
// order: the first round key is read from the key RAM at the accepting edge,
// then a load step, ten rounds through the single shared round unit, and a
// step to capture the result; in_stall stays high meanwhile and while a result
// waits to be taken. After reset, and after every key_high or key_low write, the
// key schedule is expanded into the 11-entry key RAM one round key per cycle;
// no item is accepted during that pass. IV writes take effect at the next item
// with restart_chain set.
module aes128_cbc_cipher #(
  parameter int unsigned NumRounds = aes_pkg::Rounds
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_restart_chain,
  input  logic [63:0] in_data_in_high,
  input  logic [63:0] in_data_in_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out_high,
  output logic [63:0] out_data_out_low
);

  localparam int unsigned RkDepth = NumRounds + 1;
  localparam int unsigned RkAw    = $clog2(RkDepth);

  typedef enum logic [4:0] {
    ST_EXPAND = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_RUN    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t         st_r, st_nxt;
  logic [63:0]    key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0]   chain_r, blk_r, gen_key_r;
  logic           dec_r;
  logic [RkAw-1:0] cnt_r;
  logic           exp_pend_r;
  logic           out_valid_r;
  logic [127:0]   out_r;

  logic                 ram_we;
  logic [RkAw-1:0]      ram_raddr;
  logic [127:0]         rkey;
  logic [127:0]         core_state;
  aes_pkg::rnd_ctl_t    ctl;
  logic                 in_acc;
  logic [127:0]         chain_use;
  logic [127:0]         result;
  logic                 key_wr;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || out_valid_r || exp_pend_r;
  assign key_wr = cfg_we && (cfg_index == aes_pkg::CFG_KEY_HIGH ||
                             cfg_index == aes_pkg::CFG_KEY_LOW);

  // Key RAM write during expansion
  assign ram_we = (st_r == ST_EXPAND);

  // Round key read address: round key for the next cycle of the running item
  always_comb begin
    ram_raddr = '0;
    if (st_r == ST_IDLE && in_acc) begin
      ram_raddr = in_operation ? RkAw'(NumRounds) : '0;
    end else if (st_r == ST_FETCH) begin
      ram_raddr = dec_r ? RkAw'(NumRounds - 1) : RkAw'(1);
    end else if (st_r == ST_RUN && cnt_r != RkAw'(NumRounds - 1)) begin
      ram_raddr = dec_r ? RkAw'(NumRounds - 2) - cnt_r : cnt_r + RkAw'(2);
    end
  end

  aes_ram #(.Width(128), .Depth(RkDepth)) u_rk (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (gen_key_r),
    .raddr (ram_raddr),
    .rdata (rkey)
  );

  // Drive the round unit
  always_comb begin
    ctl.load    = (st_r == ST_FETCH);
    ctl.step    = (st_r == ST_RUN);
    ctl.decrypt = dec_r;
    ctl.last    = (cnt_r == RkAw'(NumRounds - 1));
  end

  aes_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .blk   (blk_r),
    .rkey  (rkey),
    .state (core_state)
  );

  assign chain_use = in_restart_chain ? {iv_hi_r, iv_lo_r} : chain_r;
  assign result    = dec_r ? core_state ^ chain_r : core_state;

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_EXPAND: if (cnt_r == RkAw'(NumRounds)) st_nxt = ST_IDLE;
      ST_IDLE:   begin
        if (exp_pend_r) st_nxt = ST_EXPAND;
        else if (in_acc) st_nxt = ST_FETCH;
      end
      ST_FETCH:  st_nxt = ST_RUN;
      ST_RUN:    if (cnt_r == RkAw'(NumRounds - 1)) st_nxt = ST_DONE;
      ST_DONE:   st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_EXPAND;
      cnt_r       <= '0;
      exp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      iv_hi_r     <= aes_pkg::IvHighRst;
      iv_lo_r     <= aes_pkg::IvLowRst;
      chain_r     <= {aes_pkg::IvHighRst, aes_pkg::IvLowRst};
      gen_key_r   <= '0;
    end else begin
      st_r <= st_nxt;
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          aes_pkg::CFG_KEY_HIGH: key_hi_r <= cfg_data;
          aes_pkg::CFG_KEY_LOW:  key_lo_r <= cfg_data;
          aes_pkg::CFG_IV_HIGH:  iv_hi_r  <= cfg_data;
          aes_pkg::CFG_IV_LOW:   iv_lo_r  <= cfg_data;
          default: ;
        endcase
      end
      if (key_wr) begin
        exp_pend_r <= 1'b1;
      end else if (st_r == ST_IDLE && exp_pend_r) begin
        exp_pend_r <= 1'b0;
      end
      // Counter and key generator
      case (st_r)
        ST_EXPAND: begin
          cnt_r     <= (cnt_r == RkAw'(NumRounds)) ? '0 : cnt_r + RkAw'(1);
          gen_key_r <= aes_pkg::key_next(gen_key_r, 4'(cnt_r + RkAw'(1)));
        end
        ST_IDLE: begin
          cnt_r     <= '0;
          gen_key_r <= {key_hi_r, key_lo_r};
        end
        ST_RUN:  cnt_r <= cnt_r + RkAw'(1);
        ST_DONE: cnt_r <= '0;
        default: ;
      endcase
      // Load chaining value at accept
      if (in_acc) begin
        chain_r <= chain_use;
      end
      // Deliver result and update chain
      if (st_r == ST_DONE) begin
        out_valid_r <= 1'b1;
        chain_r     <= dec_r ? blk_r : core_state;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dec_r <= in_operation;
      blk_r <= in_operation ? {in_data_in_high, in_data_in_low}
                            : {in_data_in_high, in_data_in_low} ^ chain_use;
    end
    if (st_r == ST_DONE) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_out_high = out_r[127:64];
  assign out_data_out_low  = out_r[63:0];

  // Decrypt result must use the stored ciphertext as new chain
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && dec_r) |=> (chain_r == $past(blk_r)))
    else $error("chain not updated from ciphertext");

  // No item accepted while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_acc)
    else $error("item accepted with result pending");

  // Round counter stays in range while running
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (cnt_r <= RkAw'(NumRounds)))
    else $error("round counter out of range");

endmodule

>>> sim/aes128_cbc_cipher_tb.sv
// Self-checking testbench for the AES-128 CBC cipher block.
`timescale 1ns / 1ps

module aes128_cbc_cipher_tb;

  typedef struct {
    aes_pkg::op_t op;
    logic         restart;
    logic [63:0]  hi;
    logic [63:0]  lo;
  } blk_item_t;

  localparam int unsigned CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  aes_pkg::cfg_idx_t cfg_index = aes_pkg::CFG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic        in_restart_chain = 1'b0;
  logic [63:0] in_data_in_high = '0;
  logic [63:0] in_data_in_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_data_out_high;
  logic [63:0] out_data_out_low;

  aes128_cbc_cipher uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_operation, .in_restart_chain,
    .in_data_in_high, .in_data_in_low,
    .out_valid, .out_stall, .out_data_out_high, .out_data_out_low
  );

  always #5 clk = ~clk;

  // Cipher model state
  logic [7:0]   fwd_sub [256];
  logic [7:0]   rev_sub [256];
  logic [127:0] round_key [11];
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0] chain_r;

  blk_item_t    pending_q [$];
  logic [127:0] cipher_out_q [$];
  logic [127:0] seen_q [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  hold_cnt = 0;
  logic         in_taken = 1'b0;
  logic         out_taken = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build S-box from GF(2^8) inverse plus affine map
  function automatic void build_sbox();
    logic [7:0]  inv, s;
    logic [15:0] t;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      if (x != 0) begin
        inv = 8'h01;
        for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      end
      t = {inv, inv};
      s = inv ^ t[14:7] ^ t[13:6] ^ t[12:5] ^ t[11:4] ^ 8'h63;
      fwd_sub[x] = s;
      rev_sub[s] = 8'(x);
    end
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0]  rc;
    rc = 8'h01;
    round_key[0] = {key_hi_r, key_lo_r};
    for (int r = 1; r < 11; r++) begin
      {w0, w1, w2, w3} = round_key[r-1];
      t = {fwd_sub[w3[23:16]] ^ rc, fwd_sub[w3[15:8]], fwd_sub[w3[7:0]], fwd_sub[w3[31:24]]};
      w0 ^= t; w1 ^= w0; w2 ^= w1; w3 ^= w2;
      round_key[r] = {w0, w1, w2, w3};
      rc = gf_mul(rc, 8'h02);
    end
  endfunction

  function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inverse);
    for (int i = 0; i < 16; i++)
      s[127-8*i -: 8] = inverse ? rev_sub[s[127-8*i -: 8]] : fwd_sub[s[127-8*i -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] shift_rows(logic [127:0] s, logic inverse);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inverse) o[127-8*(4*((c+r)&3)+r) -: 8] = s[127-8*(4*c+r) -: 8];
        else         o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)&3)+r) -: 8];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s, logic inverse);
    logic [127:0] o;
    logic [7:0]   a [4];
    logic [7:0]   m [4];
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else         m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)&3], m[1]) ^
                                gf_mul(a[(r+2)&3], m[2]) ^ gf_mul(a[(r+3)&3], m[3]);
    end
    return o;
  endfunction

  // Advance the chain by one block and return the result block
  function automatic logic [127:0] cbc_next_block(blk_item_t it);
    logic [127:0] s;
    if (it.restart) chain_r = {iv_hi_r, iv_lo_r};
    s = {it.hi, it.lo};
    if (it.op == aes_pkg::OP_ENCRYPT) begin
      s = s ^ chain_r ^ round_key[0];
      for (int r = 1; r < 10; r++)
        s = mix_columns(shift_rows(sub_bytes(s, 1'b0), 1'b0), 1'b0) ^ round_key[r];
      s = shift_rows(sub_bytes(s, 1'b0), 1'b0) ^ round_key[10];
      chain_r = s;
    end else begin
      s = s ^ round_key[10];
      for (int r = 9; r > 0; r--)
        s = mix_columns(sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ round_key[r], 1'b1);
      s = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ round_key[0] ^ chain_r;
      chain_r = {it.hi, it.lo};
    end
    return s;
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drive the input channel at the falling edge
  always @(negedge clk) begin
    if (in_valid && in_taken) begin
      in_valid <= 1'b0;
      send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
    end else if (!in_valid && rst_n) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_q.size() > 0) begin
        blk_item_t it;
        it = pending_q.pop_front();
        in_operation     <= it.op;
        in_restart_chain <= it.restart;
        in_data_in_high  <= it.hi;
        in_data_in_low   <= it.lo;
        in_valid         <= 1'b1;
      end
    end
  end

  // Drive receiver stall: short random waits plus the long hold-off
  always @(negedge clk) begin
    if (out_taken) recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
    else if (recv_gap > 0) recv_gap--;
    out_stall <= (recv_gap > 0) || (hold_cnt > 0);
  end

  // Count down the long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) hold_cnt--;
  end

  // Predict on input accept, check on output accept
  always @(posedge clk) begin
    logic [127:0] want;
    blk_item_t    it;
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      it.op = aes_pkg::op_t'(in_operation);
      it.restart = in_restart_chain;
      it.hi = in_data_in_high;
      it.lo = in_data_in_low;
      cipher_out_q.push_back(cbc_next_block(it));
    end
    if (rst_n && out_valid && !out_stall) begin
      seen_q.push_back({out_data_out_high, out_data_out_low});
      if (cipher_out_q.size() == 0) begin
        $error("result item with nothing expected: %h %h", out_data_out_high, out_data_out_low);
        errors++;
      end else begin
        want = cipher_out_q.pop_front();
        if (out_data_out_high !== want[127:64]) begin
          $error("data_out_high expected %h actual %h", want[127:64], out_data_out_high);
          errors++;
        end
        if (out_data_out_low !== want[63:0]) begin
          $error("data_out_low expected %h actual %h", want[63:0], out_data_out_low);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("aes128_cbc_cipher regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || cipher_out_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(aes_pkg::cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aes_pkg::CFG_KEY_HIGH: begin key_hi_r = value; expand_round_keys(); end
      aes_pkg::CFG_KEY_LOW:  begin key_lo_r = value; expand_round_keys(); end
      aes_pkg::CFG_IV_HIGH:  iv_hi_r = value;
      default:               iv_lo_r = value;
    endcase
  endtask

  task automatic queue_block(aes_pkg::op_t op, logic restart, logic [63:0] hi,
                             logic [63:0] lo);
    blk_item_t it;
    it.op = op; it.restart = restart; it.hi = hi; it.lo = lo;
    pending_q.push_back(it);
  endtask

  initial begin
    build_sbox();
    key_hi_r = '0; key_lo_r = '0;
    iv_hi_r = aes_pkg::IvHighRst; iv_lo_r = aes_pkg::IvLowRst;
    chain_r = {iv_hi_r, iv_lo_r};
    expand_round_keys();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset key and IV, field extremes, both operations, restarts
    queue_block(aes_pkg::OP_ENCRYPT, 1'b0, 64'h0, 64'h0);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b0, '1, '1);
    queue_block(aes_pkg::OP_DECRYPT, 1'b0, '1, '1);
    queue_block(aes_pkg::OP_DECRYPT, 1'b1, 64'h0, 64'h0);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(aes_pkg::OP_DECRYPT, 1'b1, 64'h8000000000000000, 64'h0000000000000001);
    wait_idle();

    // Directed: standard key, IV change without restart then with restart
    write_reg(aes_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
    write_reg(aes_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_reg(aes_pkg::CFG_IV_HIGH, 64'h0);
    write_reg(aes_pkg::CFG_IV_LOW, 64'h0);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(aes_pkg::OP_DECRYPT, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b0, '1, 64'h0);
    queue_block(aes_pkg::OP_DECRYPT, 1'b0, 64'h0, '1);
    wait_idle();

    // Directed: all-ones key and IV
    write_reg(aes_pkg::CFG_KEY_HIGH, '1);
    write_reg(aes_pkg::CFG_KEY_LOW, '1);
    write_reg(aes_pkg::CFG_IV_HIGH, '1);
    write_reg(aes_pkg::CFG_IV_LOW, '1);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b1, '1, '1);
    queue_block(aes_pkg::OP_ENCRYPT, 1'b0, 64'h0, 64'h0);
    queue_block(aes_pkg::OP_DECRYPT, 1'b1, '1, '1);
    queue_block(aes_pkg::OP_DECRYPT, 1'b0, 64'h0, 64'h0);
    wait_idle();

    // Random phases: fresh key and IV, then encrypt runs whose ciphertext is
    // decrypted back under a restart, mixed with loose random blocks
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(aes_pkg::CFG_KEY_HIGH, pick_word());
      write_reg(aes_pkg::CFG_KEY_LOW, pick_word());
      write_reg(aes_pkg::CFG_IV_HIGH, pick_word());
      write_reg(aes_pkg::CFG_IV_LOW, pick_word());
      if (ph == 1) begin
        @(posedge clk);
        hold_cnt = 400;
      end
      for (int n = 0; n < 100; ) begin
        if ($urandom_range(0, 3) != 0) begin
          int unsigned len;
          len = $urandom_range(1, 6);
          wait_idle();
          seen_q.delete();
          queue_block(aes_pkg::OP_ENCRYPT, 1'b1, pick_word(), pick_word());
          for (int k = 1; k < len; k++)
            queue_block(aes_pkg::OP_ENCRYPT, 1'b0, pick_word(), pick_word());
          // Wait for the ciphertext, then decrypt it as a fresh chain
          wait_idle();
          for (int k = 0; k < len; k++)
            queue_block(aes_pkg::OP_DECRYPT, (k == 0), seen_q[k][127:64], seen_q[k][63:0]);
          n += 2 * len;
        end else begin
          queue_block(aes_pkg::op_t'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0),
                      pick_word(), pick_word());
          n++;
        end
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("aes128_cbc_cipher regression: pass");
    end else begin
      $display("aes128_cbc_cipher regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_round.sv
hdl/aes128_cbc_cipher.sv
sim/aes128_cbc_cipher_tb.sv
